@@ design/chained_range_offset_remapper_core_defines.svh @@
// ----------------------------------------------------------------------------
// Chained range offset remapper: assertion macros
// Shared macros for the concurrent checks at the end of the core.
// ----------------------------------------------------------------------------
`ifndef CHAINED_RANGE_OFFSET_REMAPPER_CORE_DEFINES_SVH
`define CHAINED_RANGE_OFFSET_REMAPPER_CORE_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define CROM_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define CROM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/crom_pkg.sv @@
// ----------------------------------------------------------------------------
// Chained range offset remapper: package
// Sizes, codes, the entry layout and the microcode program of the sequencer.
// ----------------------------------------------------------------------------
package crom_pkg;

   // Table geometry.
   localparam int STAGES            = 7;
   localparam int ENTRIES_PER_STAGE = 64;
   localparam int DEPTH             = STAGES * ENTRIES_PER_STAGE;

   localparam int VALUE_W  = 32;
   localparam int LIMIT_W  = 33;
   localparam int OFFSET_W = 33;

   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SIDX_W = (STAGES > 1) ? $clog2(STAGES) : 1;
   localparam int KIDX_W = (ENTRIES_PER_STAGE > 1) ? $clog2(ENTRIES_PER_STAGE) : 1;
   localparam int CNT_W  = $clog2(ENTRIES_PER_STAGE + 1);

   // One stored range: first value, one past the last value, and offset.
   typedef struct packed {
      logic [VALUE_W-1:0]  start;
      logic [LIMIT_W-1:0]  limit;
      logic [OFFSET_W-1:0] offset;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // Request mode codes.
   localparam logic [1:0] MODE_LOAD      = 2'd0;
   localparam logic [1:0] MODE_TRANSLATE = 2'd1;
   localparam logic [1:0] MODE_CLEAR     = 2'd2;

   // Response status codes.
   typedef enum logic [1:0] {
      STATUS_OK   = 2'd0,
      STATUS_FULL = 2'd1,
      STATUS_OOR  = 2'd2
   } status_type;

   // Microcode step addresses.
   typedef enum logic [3:0] {
      STEP_FETCH  = 4'd0,
      STEP_LOAD   = 4'd1,
      STEP_CLEAR  = 4'd2,
      STEP_T_INIT = 4'd3,
      STEP_S_INIT = 4'd4,
      STEP_SCAN   = 4'd5,
      STEP_DRAIN  = 4'd6,
      STEP_APPLY  = 4'd7,
      STEP_FINISH = 4'd8,
      STEP_RESULT = 4'd9
   } step_type;

   // Datapath operations selected by a control word.
   typedef enum logic [3:0] {
      OP_NONE,
      OP_FETCH,
      OP_LOAD,
      OP_CLEAR,
      OP_T_INIT,
      OP_S_INIT,
      OP_SCAN,
      OP_APPLY,
      OP_FINISH,
      OP_RESULT
   } dp_op_type;

   // Branch conditions; when a condition fails the step falls through, but dispatch and out-free wait in place.
   typedef enum logic [2:0] {
      BR_NONE,
      BR_ALWAYS,
      BR_DISPATCH,
      BR_EMPTY,
      BR_SCAN_MORE,
      BR_APPLY,
      BR_OUT_FREE
   } br_type;

   typedef struct packed {
      dp_op_type op;
      br_type    br;
      step_type  target;
   } ctrl_word_type;

   // Status flags from the datapath that steer branches.
   typedef struct packed {
      logic       accept;
      logic [1:0] mode;
      logic       stage_empty;
      logic       scan_more;
      logic       out_of_range;
      logic       last_stage;
      logic       out_free;
   } seq_cond_type;

   // The microcode program.
   function automatic ctrl_word_type ucode_rom(input step_type step);
      ctrl_word_type w;
      case (step)
         STEP_FETCH:  w = '{op: OP_FETCH,  br: BR_DISPATCH,  target: STEP_FETCH};
         STEP_LOAD:   w = '{op: OP_LOAD,   br: BR_ALWAYS,    target: STEP_RESULT};
         STEP_CLEAR:  w = '{op: OP_CLEAR,  br: BR_ALWAYS,    target: STEP_RESULT};
         STEP_T_INIT: w = '{op: OP_T_INIT, br: BR_NONE,      target: STEP_FETCH};
         STEP_S_INIT: w = '{op: OP_S_INIT, br: BR_EMPTY,     target: STEP_APPLY};
         STEP_SCAN:   w = '{op: OP_SCAN,   br: BR_SCAN_MORE, target: STEP_SCAN};
         STEP_DRAIN:  w = '{op: OP_NONE,   br: BR_NONE,      target: STEP_FETCH};
         STEP_APPLY:  w = '{op: OP_APPLY,  br: BR_APPLY,     target: STEP_S_INIT};
         STEP_FINISH: w = '{op: OP_FINISH, br: BR_NONE,      target: STEP_FETCH};
         STEP_RESULT: w = '{op: OP_RESULT, br: BR_OUT_FREE,  target: STEP_FETCH};
         default:     w = '{op: OP_NONE,   br: BR_ALWAYS,    target: STEP_FETCH};
      endcase
      return w;
   endfunction

endpackage

@@ design/chained_range_offset_remapper_core.sv @@
// ----------------------------------------------------------------------------
// Chained range offset remapper core
// Chain of range tables that remaps a value stage by stage.
// ----------------------------------------------------------------------------
// Each request beat gives exactly one response beat. A load, a clear and the
// unused mode each go from acceptance to the result step. A translate visits
// the stages in order; its length is set by the single read port of the entry
// memory, through which each stage that holds entries is scanned one entry per
// cycle, while an empty stage is not scanned.
// The block works on one request at a time; a new request is taken while the
// previous response still waits in the output register. No clearing pass is
// needed after reset: only entries below each stage's fill count are read.
`include "chained_range_offset_remapper_core_defines.svh"

module chained_range_offset_remapper_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [2:0]  req_stage,
   input  logic [31:0] req_dest_base,
   input  logic [31:0] req_src_base,
   input  logic [31:0] req_span_length,
   input  logic [31:0] req_seed_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_mapped_value,
   output logic [31:0] rsp_lowest_so_far
);

   localparam int VW = crom_pkg::VALUE_W;
   localparam int LW = crom_pkg::LIMIT_W;
   localparam int OW = crom_pkg::OFFSET_W;
   localparam int SW = crom_pkg::SIDX_W;
   localparam int KW = crom_pkg::KIDX_W;
   localparam int CW = crom_pkg::CNT_W;
   localparam int AW = crom_pkg::ADDR_W;

   crom_pkg::ctrl_word_type ctrl;
   crom_pkg::seq_cond_type  cond;

   // Latched request beat.
   logic [2:0]    stage_ff,  stage_in;
   logic [VW-1:0] dest_ff,   dest_in;
   logic [VW-1:0] src_ff,    src_in;
   logic [VW-1:0] len_ff,    len_in;
   logic [VW-1:0] seed_ff,   seed_in;

   // Working registers.
   logic [VW-1:0] v_ff, v_in;
   logic [SW-1:0] s_ff, s_in;
   logic [CW-1:0] k_ff, k_in;
   logic          found_ff, found_in;
   logic          pend_ff, pend_in;
   logic [VW-1:0] best_start_ff, best_start_in;
   logic [LW-1:0] best_limit_ff, best_limit_in;
   logic [OW-1:0] best_off_ff, best_off_in;
   crom_pkg::status_type status_ff, status_in;
   logic [VW-1:0] mapped_ff, mapped_in;
   logic [VW-1:0] running_min_ff, running_min_in;
   logic [CW-1:0] count_ff [crom_pkg::STAGES];
   logic [CW-1:0] count_in [crom_pkg::STAGES];

   // Output register.
   logic          rsp_valid_ff, rsp_valid_in;
   crom_pkg::status_type rsp_status_ff, rsp_status_in;
   logic [VW-1:0] rsp_mapped_ff, rsp_mapped_in;
   logic [VW-1:0] rsp_lowest_ff, rsp_lowest_in;

   // Memory interface.
   logic                      wr_en;
   logic [AW-1:0]             wr_addr;
   crom_pkg::entry_type       wr_entry;
   logic                      rd_en;
   logic [AW-1:0]             rd_addr;
   logic [crom_pkg::ENTRY_W-1:0] rd_data;
   crom_pkg::entry_type       rd_entry;

   // Shared datapath signals.
   logic          accept;
   logic          out_free;
   logic          stage_ok;
   logic [SW-1:0] cnt_idx;
   logic [CW-1:0] cnt_sel;
   logic [CW-1:0] k_next;
   logic          match;
   logic [VW+1:0] sum;
   logic          oor;
   logic          last_stage;

   // Handshake.
   assign req_stall = (ctrl.op != crom_pkg::OP_FETCH);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // One fill count is read per cycle: the load's stage or the scan's stage.
   assign stage_ok = (int'(stage_ff) < crom_pkg::STAGES);
   always_comb begin
      if (ctrl.op == crom_pkg::OP_LOAD) begin
         cnt_idx = stage_ok ? SW'(stage_ff) : '0;
      end else begin
         cnt_idx = s_ff;
      end
   end
   assign cnt_sel = count_ff[cnt_idx];
   assign k_next  = CW'(k_ff + 1'b1);

   // Range check and offset add for the chosen entry.
   assign match      = found_ff && ({1'b0, v_ff} < best_limit_ff);
   assign sum        = {2'b00, v_ff} + {best_off_ff[OW-1], best_off_ff};
   assign oor        = match && (sum[VW+1] || sum[VW]);
   assign last_stage = (s_ff == SW'(crom_pkg::STAGES - 1));

   // Memory addressing and write data.
   assign wr_addr = AW'(int'(cnt_idx) * crom_pkg::ENTRIES_PER_STAGE + int'(cnt_sel));
   assign rd_addr = AW'(int'(s_ff) * crom_pkg::ENTRIES_PER_STAGE + int'(k_ff[KW-1:0]));
   assign wr_entry.start  = src_ff;
   assign wr_entry.limit  = LW'(src_ff) + LW'(len_ff);
   assign wr_entry.offset = OW'(dest_ff) - OW'(src_ff);
   assign rd_entry        = crom_pkg::entry_type'(rd_data);

   // Datapath operations selected by the control word.
   always_comb begin
      stage_in       = stage_ff;
      dest_in        = dest_ff;
      src_in         = src_ff;
      len_in         = len_ff;
      seed_in        = seed_ff;
      v_in           = v_ff;
      s_in           = s_ff;
      k_in           = k_ff;
      found_in       = found_ff;
      best_start_in  = best_start_ff;
      best_limit_in  = best_limit_ff;
      best_off_in    = best_off_ff;
      status_in      = status_ff;
      mapped_in      = mapped_ff;
      running_min_in = running_min_ff;
      count_in       = count_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_mapped_in  = rsp_mapped_ff;
      rsp_lowest_in  = rsp_lowest_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      wr_en          = 1'b0;
      rd_en          = 1'b0;

      case (ctrl.op)
         crom_pkg::OP_FETCH: begin
            if (accept) begin
               stage_in  = req_stage;
               dest_in   = req_dest_base;
               src_in    = req_src_base;
               len_in    = req_span_length;
               seed_in   = req_seed_value;
               status_in = crom_pkg::STATUS_OK;
               mapped_in = '0;
            end
         end
         crom_pkg::OP_LOAD: begin
            if (stage_ok) begin
               if (cnt_sel >= CW'(crom_pkg::ENTRIES_PER_STAGE)) begin
                  status_in = crom_pkg::STATUS_FULL;
               end else begin
                  wr_en             = 1'b1;
                  count_in[cnt_idx] = CW'(cnt_sel + 1'b1);
               end
            end
         end
         crom_pkg::OP_CLEAR: begin
            for (int i = 0; i < crom_pkg::STAGES; i++) begin
               count_in[i] = '0;
            end
            running_min_in = '1;
         end
         crom_pkg::OP_T_INIT: begin
            v_in = seed_ff;
            s_in = '0;
         end
         crom_pkg::OP_S_INIT: begin
            k_in     = '0;
            found_in = 1'b0;
         end
         crom_pkg::OP_SCAN: begin
            rd_en = 1'b1;
            k_in  = k_next;
         end
         crom_pkg::OP_APPLY: begin
            if (oor) begin
               status_in = crom_pkg::STATUS_OOR;
            end else begin
               if (match) begin
                  v_in = sum[VW-1:0];
               end
               if (!last_stage) begin
                  s_in = SW'(s_ff + 1'b1);
               end
            end
         end
         crom_pkg::OP_FINISH: begin
            mapped_in = v_ff;
            if (v_ff < running_min_ff) begin
               running_min_in = v_ff;
            end
         end
         crom_pkg::OP_RESULT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_mapped_in = mapped_ff;
               rsp_lowest_in = running_min_ff;
            end
         end
         default: begin
         end
      endcase

      // Compare the entry read in the previous cycle against the best so far.
      // A strictly greater start is needed, so ties keep the earliest entry.
      if (pend_ff && (rd_entry.start <= v_ff)
          && (!found_ff || (rd_entry.start > best_start_ff))) begin
         found_in      = 1'b1;
         best_start_in = rd_entry.start;
         best_limit_in = rd_entry.limit;
         best_off_in   = rd_entry.offset;
      end
   end

   assign pend_in = (ctrl.op == crom_pkg::OP_SCAN);

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff        <= 1'b0;
         found_ff       <= 1'b0;
         running_min_ff <= '1;
         rsp_valid_ff   <= 1'b0;
         for (int i = 0; i < crom_pkg::STAGES; i++) begin
            count_ff[i] <= '0;
         end
      end else begin
         pend_ff        <= pend_in;
         found_ff       <= found_in;
         running_min_ff <= running_min_in;
         rsp_valid_ff   <= rsp_valid_in;
         count_ff       <= count_in;
      end
   end

   // Payload and working registers.
   always_ff @(posedge clock) begin
      stage_ff      <= stage_in;
      dest_ff       <= dest_in;
      src_ff        <= src_in;
      len_ff        <= len_in;
      seed_ff       <= seed_in;
      v_ff          <= v_in;
      s_ff          <= s_in;
      k_ff          <= k_in;
      best_start_ff <= best_start_in;
      best_limit_ff <= best_limit_in;
      best_off_ff   <= best_off_in;
      status_ff     <= status_in;
      mapped_ff     <= mapped_in;
      rsp_status_ff <= rsp_status_in;
      rsp_mapped_ff <= rsp_mapped_in;
      rsp_lowest_ff <= rsp_lowest_in;
   end

   // Branch conditions for the sequencer.
   assign cond.accept       = accept;
   assign cond.mode         = req_mode;
   assign cond.stage_empty  = (cnt_sel == '0);
   assign cond.scan_more    = (k_next < cnt_sel);
   assign cond.out_of_range = oor;
   assign cond.last_stage   = last_stage;
   assign cond.out_free     = out_free;

   crom_seq u_seq (
      .clock (clock),
      .reset (reset),
      .cond  (cond),
      .ctrl  (ctrl)
   );

   crom_ram #(
      .WIDTH (crom_pkg::ENTRY_W),
      .DEPTH (crom_pkg::DEPTH)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Response ports.
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_mapped_value  = rsp_mapped_ff;
   assign rsp_lowest_so_far = rsp_lowest_ff;

   // Checks.
   `CROM_ASSERT_SAME(a_scan_in_fill, clock, reset, ctrl.op == crom_pkg::OP_SCAN, k_ff < cnt_sel, "scan read beyond the stage fill count")
   `CROM_ASSERT_SAME(a_rsp_from_result, clock, reset, $rose(rsp_valid_ff), $past(ctrl.op) == crom_pkg::OP_RESULT, "response beat raised outside the result step")
   `CROM_ASSERT_NEXT(a_min_monotone, clock, reset, ctrl.op != crom_pkg::OP_CLEAR, running_min_ff <= $past(running_min_ff), "running minimum grew without a clear")
   `CROM_ASSERT_SAME(a_oor_zero, clock, reset, rsp_valid_ff && (rsp_status_ff == crom_pkg::STATUS_OOR), rsp_mapped_ff == '0, "out of range beat carries a nonzero value")

endmodule

@@ design/crom_ram.sv @@
// ----------------------------------------------------------------------------
// Chained range offset remapper: generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module crom_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/crom_seq.sv @@
// ----------------------------------------------------------------------------
// Chained range offset remapper: microcode sequencer
// Step counter over the control program, with conditional jumps.
// ----------------------------------------------------------------------------
module crom_seq (
   input  logic                    clock,
   input  logic                    reset,
   input  crom_pkg::seq_cond_type  cond,
   output crom_pkg::ctrl_word_type ctrl
);

   crom_pkg::step_type step_ff;
   crom_pkg::step_type step_in;
   crom_pkg::step_type step_next;

   // Control word of the current step.
   assign ctrl      = crom_pkg::ucode_rom(step_ff);
   assign step_next = crom_pkg::step_type'(step_ff + 4'd1);

   // Next step selection.
   always_comb begin
      step_in = step_ff;
      case (ctrl.br)
         crom_pkg::BR_NONE: begin
            step_in = step_next;
         end
         crom_pkg::BR_ALWAYS: begin
            step_in = ctrl.target;
         end
         crom_pkg::BR_DISPATCH: begin
            if (cond.accept) begin
               case (cond.mode)
                  crom_pkg::MODE_LOAD:      step_in = crom_pkg::STEP_LOAD;
                  crom_pkg::MODE_TRANSLATE: step_in = crom_pkg::STEP_T_INIT;
                  crom_pkg::MODE_CLEAR:     step_in = crom_pkg::STEP_CLEAR;
                  default:                  step_in = crom_pkg::STEP_RESULT;
               endcase
            end
         end
         crom_pkg::BR_EMPTY: begin
            step_in = cond.stage_empty ? ctrl.target : step_next;
         end
         crom_pkg::BR_SCAN_MORE: begin
            step_in = cond.scan_more ? ctrl.target : step_next;
         end
         crom_pkg::BR_APPLY: begin
            if (cond.out_of_range) begin
               step_in = crom_pkg::STEP_RESULT;
            end else if (cond.last_stage) begin
               step_in = step_next;
            end else begin
               step_in = ctrl.target;
            end
         end
         crom_pkg::BR_OUT_FREE: begin
            if (cond.out_free) begin
               step_in = ctrl.target;
            end
         end
         default: begin
            step_in = crom_pkg::STEP_FETCH;
         end
      endcase
   end

   // Step counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= crom_pkg::STEP_FETCH;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule
